// ----- hdl/smvg_pkg.sv -----
package smvg_pkg;

  localparam int MAX_RESOLUTION = 4096;
  localparam int FRACTION_BITS  = 16;

  localparam int RES_W   = 13;
  localparam int STACK_W = 11;
  localparam int SLICE_W = 13;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int POS_W   = 32;
  localparam int RAD_W   = 31;
  localparam int NORM_W  = 16;
  localparam int COL_W   = 15;
  localparam int TEX_W   = 17;

  // restoring divider: one quotient bit per step
  localparam int DIV_STEPS = 33;
  localparam int DIV_REM_W = 13;
  localparam int DVD_W     = 45;

  localparam int CORDIC_STAGES = 30;
  localparam int XY_W = 33;
  localparam int Z_W  = 34;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sh026DD3B6A;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESOLUTION = 3'd0,
    CFG_CENTRE_X   = 3'd1,
    CFG_CENTRE_Y   = 3'd2,
    CFG_CENTRE_Z   = 3'd3,
    CFG_RADIUS     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_STEPS-1:0] word;
  } div_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] k);
    logic [29:0] a;
    case (k)
      5'd0:  a = 30'h3243F6A8;
      5'd1:  a = 30'h1DAC6705;
      5'd2:  a = 30'h0FADBAFC;
      5'd3:  a = 30'h07F56EA6;
      5'd4:  a = 30'h03FEAB76;
      5'd5:  a = 30'h01FFD55B;
      5'd6:  a = 30'h00FFFAAA;
      5'd7:  a = 30'h007FFF55;
      5'd8:  a = 30'h003FFFEA;
      5'd9:  a = 30'h001FFFFD;
      5'd10: a = 30'h000FFFFF;
      5'd11: a = 30'h0007FFFF;
      5'd12: a = 30'h0003FFFF;
      5'd13: a = 30'h0001FFFF;
      5'd14: a = 30'h0000FFFF;
      5'd15: a = 30'h00007FFF;
      5'd16: a = 30'h00003FFF;
      5'd17: a = 30'h00001FFF;
      5'd18: a = 30'h00000FFF;
      5'd19: a = 30'h000007FF;
      5'd20: a = 30'h000003FF;
      5'd21: a = 30'h000001FF;
      5'd22: a = 30'h000000FF;
      5'd23: a = 30'h0000007F;
      5'd24: a = 30'h0000003F;
      5'd25: a = 30'h0000001F;
      5'd26: a = 30'h0000000F;
      5'd27: a = 30'h00000007;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/smvg_in_if.sv -----
interface smvg_in_if import smvg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STACK_W-1:0] stack_index;
  logic [SLICE_W-1:0] slice_index;

  modport source (output valid, stack_index, slice_index, input ready);
  modport sink   (input valid, stack_index, slice_index, output ready);
endinterface

// ----- hdl/smvg_out_if.sv -----
interface smvg_out_if import smvg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [POS_W-1:0]  pos_z;
  logic signed [NORM_W-1:0] norm_x;
  logic signed [NORM_W-1:0] norm_y;
  logic signed [NORM_W-1:0] norm_z;
  logic [COL_W-1:0]         colour_r;
  logic [COL_W-1:0]         colour_g;
  logic [COL_W-1:0]         colour_b;
  logic [TEX_W-1:0]         tex_u;
  logic [TEX_W-1:0]         tex_v;
  logic                     upper_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  colour_r, colour_g, colour_b, tex_u, tex_v, upper_vertex,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  colour_r, colour_g, colour_b, tex_u, tex_v, upper_vertex,
                  output ready);
endinterface

// ----- hdl/smvg_div_cell.sv -----
module smvg_div_cell import smvg_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_REM_W-1:0] dsr,
  input  div_t                 d_i,
  output div_t                 d_o
);

  logic [DIV_REM_W:0] trial;
  logic [DIV_REM_W:0] diff;
  logic               take;
  div_t               d_nxt;
  div_t               d_r;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {d_i.rem, d_i.word[DIV_STEPS-1]};
    diff  = trial - {1'b0, dsr};
    take  = (trial >= {1'b0, dsr});
    d_nxt.rem  = take ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
    d_nxt.word = {d_i.word[DIV_STEPS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_o = d_r;

endmodule

// ----- hdl/smvg_cordic_cell.sv -----
module smvg_cordic_cell import smvg_pkg::*; (
  input  logic       clk,
  input  logic       en,
  input  logic [4:0] stage,
  input  cordic_t    c_i,
  output cordic_t    c_o
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  ang;
  cordic_t                c_nxt;
  cordic_t                c_r;

  always_comb begin
    dx  = c_i.y >>> stage;
    dy  = c_i.x >>> stage;
    ang = $signed({{(Z_W-30){1'b0}}, atan_q30(stage)});
    if (!c_i.z[Z_W-1]) begin
      c_nxt.x = c_i.x - dx;
      c_nxt.y = c_i.y + dy;
      c_nxt.z = c_i.z - ang;
    end else begin
      c_nxt.x = c_i.x + dx;
      c_nxt.y = c_i.y - dy;
      c_nxt.z = c_i.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r <= c_nxt;
    end
  end

  assign c_o = c_r;

endmodule

// ----- hdl/sphere_mesh_vertex_generator_unit.sv -----
// The first vertex of a pair is offered once its index pair has passed every pipeline register;
// the second vertex follows in the next cycle that the sink takes the first.
// One index pair enters per cycle while the pipe may advance; two vertices leave per pair
// through one output port, so that port sets the sustained rate of pairs.
// Reset (rst_n, synchronous, active low) empties the pipeline and the result queue and
// restores resolution 32, centre 0 and radius 1.0.
module sphere_mesh_vertex_generator_unit import smvg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  smvg_in_if.sink              in_ch,
  smvg_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Pipeline map (valid bit index): index register, divider cells, angle scaling,
  // CORDIC cells, quadrant fold, normal products, rounding, radius products.
  localparam int DIV_FIRST    = 1;
  localparam int Z_IDX        = DIV_FIRST + DIV_STEPS;
  localparam int CORDIC_FIRST = Z_IDX + 1;
  localparam int M_IDX        = CORDIC_FIRST + CORDIC_STAGES;
  localparam int P3_IDX       = M_IDX + 3;
  localparam int PIPE_DEPTH   = P3_IDX + 1;

  // divider lanes: longitude, two latitudes, three texture coordinates
  localparam int DV_LON  = 0;
  localparam int DV_LAT0 = 1;
  localparam int DV_LAT1 = 2;
  localparam int DV_TU   = 3;
  localparam int DV_TV0  = 4;
  localparam int DV_TV1  = 5;
  localparam int DV_LANES = 6;
  localparam int ANG_LANES = 3;

  typedef struct packed {
    logic [ANG_LANES-1:0][1:0] quad;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v0;
    logic [TEX_W-1:0]          tex_v1;
  } side_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
    logic [COL_W-1:0]         colour_r;
    logic [COL_W-1:0]         colour_g;
    logic [COL_W-1:0]         colour_b;
    logic [TEX_W-1:0]         tex_u;
    logic [TEX_W-1:0]         tex_v;
  } vertex_t;

  typedef struct packed {
    vertex_t v1;
    vertex_t v0;
  } pair_t;

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [XY_W-1:0] round_q30(input logic signed [65:0] p);
    logic signed [65:0] t;
    t = p + 66'sd536870912;
    return t[XY_W+29:30];
  endfunction

  function automatic logic signed [NORM_W-1:0] to_q15(input logic signed [XY_W-1:0] e);
    logic signed [XY_W:0]   t;
    logic signed [XY_W-15:0] v;
    logic signed [NORM_W-1:0] r;
    t = {e[XY_W-1], e} + 34'sd16384;
    v = t[XY_W:15];
    if (v > 19'sd32767) begin
      r = 16'sd32767;
    end else if (v < -19'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[NORM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] place(input logic signed [64:0] rp,
                                                    input logic signed [POS_W-1:0] ctr);
    logic signed [64:0] t;
    logic signed [34:0] sh;
    logic signed [35:0] sum;
    logic signed [POS_W-1:0] r;
    t   = rp + 65'sd536870912;
    sh  = t[64:30];
    sum = {sh[34], sh} + {{4{ctr[POS_W-1]}}, ctr};
    if (sum > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (sum < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = sum[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COL_W-1:0] mag(input logic signed [NORM_W-1:0] v);
    logic signed [NORM_W-1:0] a;
    a = v[NORM_W-1] ? -v : v;
    return a[COL_W-1:0];
  endfunction

  // ---------------------------------------------------------- configuration
  logic [RES_W-1:0]        resolution_r;
  logic signed [POS_W-1:0] centre_x_r;
  logic signed [POS_W-1:0] centre_y_r;
  logic signed [POS_W-1:0] centre_z_r;
  logic [RAD_W-1:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resolution_r <= RES_W'(32);
      centre_x_r   <= '0;
      centre_y_r   <= '0;
      centre_z_r   <= '0;
      radius_r     <= RAD_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESOLUTION: resolution_r <= cfg_data[RES_W-1:0];
        CFG_CENTRE_X:   centre_x_r   <= cfg_data;
        CFG_CENTRE_Y:   centre_y_r   <= cfg_data;
        CFG_CENTRE_Z:   centre_z_r   <= cfg_data;
        CFG_RADIUS:     radius_r     <= cfg_data[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the slice count; stacks are its integer half.
  logic [RES_W-1:0]   n_eff;
  logic [RES_W-2:0]   half;
  logic [RES_W-1:0]   two_h;
  logic [RES_W-2:0]   j_max;

  always_comb begin
    if (resolution_r < RES_W'(2)) begin
      n_eff = RES_W'(2);
    end else if (resolution_r > RES_W'(MAX_RESOLUTION)) begin
      n_eff = RES_W'(MAX_RESOLUTION);
    end else begin
      n_eff = resolution_r;
    end
    half  = n_eff[RES_W-1:1];
    two_h = {half, 1'b0};
    j_max = half - 1'b1;
  end

  // -------------------------------------------------------------- flow
  logic              adv;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [1:0]        q_cnt_r;
  logic              q_phase_r;
  logic              pop_any;
  logic              pop_last;
  logic              push;

  assign pop_any  = out_ch.valid && out_ch.ready;
  assign pop_last = pop_any && q_phase_r;
  // the whole pipe moves while the result queue has a free pair slot or its last vertex is taken
  assign adv      = (q_cnt_r != 2'd2) || pop_last;
  assign push     = adv && vld_r[P3_IDX];
  // hold off the source while reset is applied
  assign in_ch.ready = adv && rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_ch.valid};
    end
  end

  // ------------------------------------------------------ index register
  logic [STACK_W-1:0] j_cl;
  logic [SLICE_W-1:0] i_cl;
  logic [STACK_W-1:0] j_r;
  logic [SLICE_W-1:0] i_r;

  always_comb begin
    j_cl = ({1'b0, in_ch.stack_index} > j_max) ? j_max[STACK_W-1:0] : in_ch.stack_index;
    i_cl = (in_ch.slice_index > n_eff) ? n_eff : in_ch.slice_index;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_r <= j_cl;
      i_r <= i_cl;
    end
  end

  // ------------------------------------------------------------ dividers
  logic [STACK_W:0]   ring1;
  logic [DVD_W-1:0]   dvd [DV_LANES];
  logic [DIV_REM_W-1:0] dsr [DV_LANES];
  div_t               div_s [DV_LANES][DIV_STEPS+1];

  always_comb begin
    ring1 = {1'b0, j_r} + 1'b1;
    dvd[DV_LON]  = (DVD_W'(i_r) << 32) + DVD_W'(half);
    dvd[DV_LAT0] = (DVD_W'(j_r) << 32) + DVD_W'(half);
    dvd[DV_LAT1] = (DVD_W'(ring1) << 32) + DVD_W'(half);
    dvd[DV_TU]   = (DVD_W'(n_eff - i_r) << FRACTION_BITS) + DVD_W'(half);
    dvd[DV_TV0]  = (DVD_W'(j_r) << (FRACTION_BITS + 1)) + DVD_W'(half);
    dvd[DV_TV1]  = (DVD_W'(ring1) << (FRACTION_BITS + 1)) + DVD_W'(half);
    dsr[DV_LON]  = n_eff;
    dsr[DV_LAT0] = two_h;
    dsr[DV_LAT1] = two_h;
    dsr[DV_TU]   = n_eff;
    dsr[DV_TV0]  = n_eff;
    dsr[DV_TV1]  = n_eff;
  end

  for (genvar l = 0; l < DV_LANES; l++) begin : g_div
    // the quotient fits 33 bits, so the dividend bits above them seed the remainder
    assign div_s[l][0].rem  = DIV_REM_W'(dvd[l][DVD_W-1:DIV_STEPS]);
    assign div_s[l][0].word = dvd[l][DIV_STEPS-1:0];
    for (genvar s = 0; s < DIV_STEPS; s++) begin : g_cell
      smvg_div_cell u_cell (
        .clk (clk),
        .en  (adv),
        .dsr (dsr[l]),
        .d_i (div_s[l][s]),
        .d_o (div_s[l][s+1])
      );
    end
  end

  // ------------------------------------------------- angle scaling stage
  logic [31:0]  phase   [ANG_LANES];
  logic [61:0]  z_prod  [ANG_LANES];
  logic [31:0]  z_r     [ANG_LANES];
  side_t        side_nxt;
  side_t        side_r;

  always_comb begin
    for (int a = 0; a < ANG_LANES; a++) begin
      // phase in turns, shifted by a quarter turn
      phase[a] = div_s[a][DIV_STEPS].word[31:0] - 32'h40000000;
      z_prod[a] = 62'(phase[a][29:0]) * 62'(HALF_PI_Q30) + 62'd536870912;
      side_nxt.quad[a] = phase[a][31:30];
    end
    side_nxt.tex_u  = div_s[DV_TU][DIV_STEPS].word[TEX_W-1:0];
    side_nxt.tex_v0 = div_s[DV_TV0][DIV_STEPS].word[TEX_W-1:0];
    side_nxt.tex_v1 = div_s[DV_TV1][DIV_STEPS].word[TEX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < ANG_LANES; a++) begin
        z_r[a] <= z_prod[a][61:30];
      end
      side_r <= side_nxt;
    end
  end

  // --------------------------------------------------------------- CORDIC
  cordic_t cor_s [ANG_LANES][CORDIC_STAGES+1];
  side_t   side_line_r [CORDIC_STAGES];

  for (genvar a = 0; a < ANG_LANES; a++) begin : g_cor
    assign cor_s[a][0].x = CORDIC_GAIN;
    assign cor_s[a][0].y = '0;
    assign cor_s[a][0].z = $signed({{(Z_W-32){1'b0}}, z_r[a]});
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
      smvg_cordic_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .stage (5'(s)),
        .c_i   (cor_s[a][s]),
        .c_o   (cor_s[a][s+1])
      );
    end
  end

  // carry quadrants and texture coordinates alongside the rotation cells
  always_ff @(posedge clk) begin
    if (adv) begin
      side_line_r[0] <= side_r;
      for (int s = 1; s < CORDIC_STAGES; s++) begin
        side_line_r[s] <= side_line_r[s-1];
      end
    end
  end

  // -------------------------------------------------------- quadrant fold
  logic signed [XY_W-1:0] fc [ANG_LANES];
  logic signed [XY_W-1:0] fs [ANG_LANES];
  logic signed [XY_W-1:0] m_cos_r [ANG_LANES];
  logic signed [XY_W-1:0] m_sin_r [ANG_LANES];
  side_t                  m_side_r;

  always_comb begin
    for (int a = 0; a < ANG_LANES; a++) begin
      case (side_line_r[CORDIC_STAGES-1].quad[a])
        2'd0: begin
          fc[a] = cor_s[a][CORDIC_STAGES].x;
          fs[a] = cor_s[a][CORDIC_STAGES].y;
        end
        2'd1: begin
          fc[a] = -cor_s[a][CORDIC_STAGES].y;
          fs[a] = cor_s[a][CORDIC_STAGES].x;
        end
        2'd2: begin
          fc[a] = -cor_s[a][CORDIC_STAGES].x;
          fs[a] = -cor_s[a][CORDIC_STAGES].y;
        end
        default: begin
          fc[a] = cor_s[a][CORDIC_STAGES].y;
          fs[a] = -cor_s[a][CORDIC_STAGES].x;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < ANG_LANES; a++) begin
        m_cos_r[a] <= fc[a];
        m_sin_r[a] <= fs[a];
      end
      m_side_r <= side_line_r[CORDIC_STAGES-1];
    end
  end

  // ------------------------------------------------------- normal products
  // ring k uses lane DV_LAT0 + k; longitude is lane DV_LON
  logic signed [65:0]     p1_x_r [2];
  logic signed [65:0]     p1_z_r [2];
  logic signed [XY_W-1:0] p1_y_r [2];
  side_t                  p1_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        p1_x_r[k] <= 66'(m_cos_r[DV_LAT0+k]) * 66'(m_cos_r[DV_LON]);
        p1_z_r[k] <= 66'(m_cos_r[DV_LAT0+k]) * 66'(m_sin_r[DV_LON]);
        p1_y_r[k] <= m_sin_r[DV_LAT0+k];
      end
      p1_side_r <= m_side_r;
    end
  end

  logic signed [XY_W-1:0] p2_x_r [2];
  logic signed [XY_W-1:0] p2_y_r [2];
  logic signed [XY_W-1:0] p2_z_r [2];
  side_t                  p2_side_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        p2_x_r[k] <= round_q30(p1_x_r[k]);
        p2_y_r[k] <= p1_y_r[k];
        p2_z_r[k] <= round_q30(p1_z_r[k]);
      end
      p2_side_r <= p1_side_r;
    end
  end

  // ------------------------------------------------------- radius products
  logic signed [RAD_W:0]    rad_s;
  logic signed [64:0]       p3_rx_r [2];
  logic signed [64:0]       p3_ry_r [2];
  logic signed [64:0]       p3_rz_r [2];
  logic signed [NORM_W-1:0] p3_nx_r [2];
  logic signed [NORM_W-1:0] p3_ny_r [2];
  logic signed [NORM_W-1:0] p3_nz_r [2];
  side_t                    p3_side_r;

  assign rad_s = $signed({1'b0, radius_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        p3_rx_r[k] <= 65'(rad_s) * 65'(p2_x_r[k]);
        p3_ry_r[k] <= 65'(rad_s) * 65'(p2_y_r[k]);
        p3_rz_r[k] <= 65'(rad_s) * 65'(p2_z_r[k]);
        p3_nx_r[k] <= to_q15(p2_x_r[k]);
        p3_ny_r[k] <= to_q15(p2_y_r[k]);
        p3_nz_r[k] <= to_q15(p2_z_r[k]);
      end
      p3_side_r <= p2_side_r;
    end
  end

  // ------------------------------------------------------------ result queue
  pair_t pair_nxt;
  pair_t q_r [2];
  logic  q_wr_r;
  logic  q_rd_r;
  vertex_t cur;

  always_comb begin
    pair_nxt.v0.pos_x  = place(p3_rx_r[0], centre_x_r);
    pair_nxt.v0.pos_y  = place(p3_ry_r[0], centre_y_r);
    pair_nxt.v0.pos_z  = place(p3_rz_r[0], centre_z_r);
    pair_nxt.v0.norm_x = p3_nx_r[0];
    pair_nxt.v0.norm_y = p3_ny_r[0];
    pair_nxt.v0.norm_z = p3_nz_r[0];
    pair_nxt.v0.tex_u  = p3_side_r.tex_u;
    pair_nxt.v0.tex_v  = p3_side_r.tex_v0;
    pair_nxt.v1.pos_x  = place(p3_rx_r[1], centre_x_r);
    pair_nxt.v1.pos_y  = place(p3_ry_r[1], centre_y_r);
    pair_nxt.v1.pos_z  = place(p3_rz_r[1], centre_z_r);
    pair_nxt.v1.norm_x = p3_nx_r[1];
    pair_nxt.v1.norm_y = p3_ny_r[1];
    pair_nxt.v1.norm_z = p3_nz_r[1];
    pair_nxt.v1.tex_u  = p3_side_r.tex_u;
    pair_nxt.v1.tex_v  = p3_side_r.tex_v1;
    // both vertices take the colour of the lower ring
    pair_nxt.v0.colour_r = mag(p3_nx_r[0]);
    pair_nxt.v0.colour_g = mag(p3_ny_r[0]);
    pair_nxt.v0.colour_b = mag(p3_nz_r[0]);
    pair_nxt.v1.colour_r = pair_nxt.v0.colour_r;
    pair_nxt.v1.colour_g = pair_nxt.v0.colour_g;
    pair_nxt.v1.colour_b = pair_nxt.v0.colour_b;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[q_wr_r] <= pair_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r   <= '0;
      q_wr_r    <= 1'b0;
      q_rd_r    <= 1'b0;
      q_phase_r <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_r + {1'b0, push} - {1'b0, pop_last};
      if (push) begin
        q_wr_r <= ~q_wr_r;
      end
      // advance to the upper vertex, then drop the pair
      if (pop_any) begin
        q_phase_r <= ~q_phase_r;
      end
      if (pop_last) begin
        q_rd_r <= ~q_rd_r;
      end
    end
  end

  assign cur = q_phase_r ? q_r[q_rd_r].v1 : q_r[q_rd_r].v0;

  assign out_ch.valid        = (q_cnt_r != 2'd0);
  assign out_ch.pos_x        = cur.pos_x;
  assign out_ch.pos_y        = cur.pos_y;
  assign out_ch.pos_z        = cur.pos_z;
  assign out_ch.norm_x       = cur.norm_x;
  assign out_ch.norm_y       = cur.norm_y;
  assign out_ch.norm_z       = cur.norm_z;
  assign out_ch.colour_r     = cur.colour_r;
  assign out_ch.colour_g     = cur.colour_g;
  assign out_ch.colour_b     = cur.colour_b;
  assign out_ch.tex_u        = cur.tex_u;
  assign out_ch.tex_v        = cur.tex_v;
  assign out_ch.upper_vertex = q_phase_r;

endmodule
